### rtl/wsbr_pkg.sv
// Shared types and constants for the wheel slip brake release block.
// No dependencies; imported by the top level.
package wsbr_pkg;

    // Field widths fixed by the interface
    localparam int FUNC_BITS   = 2;
    localparam int SAMPLE_BITS = 8;
    localparam int CMD_BITS    = 8;
    localparam int PULSE_BITS  = 12;
    localparam int STATUS_BITS = 2;
    localparam int THRESH_BITS = 16;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 1;

    // Command and pulse constants
    localparam logic [CMD_BITS-1:0]   CMD_BIAS        = 8'd128;
    localparam logic [CMD_BITS-1:0]   MAX_CMD_RESET   = 8'd235;
    localparam logic [PULSE_BITS-1:0] PULSE_BASE_US   = 12'd500;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET   = 16'd0;

    // Event kinds
    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_FRONT_EDGE = 2'd1,
        FUNC_REAR_EDGE  = 2'd2,
        FUNC_SAMPLE     = 2'd3
    } func_t;

    // Slip status codes
    typedef enum logic [STATUS_BITS-1:0] {
        ST_BALANCED   = 2'd0,
        ST_FRONT_SLOW = 2'd1,
        ST_REAR_SLOW  = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIFF_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_COMMAND    = 1'd1;

endpackage

### rtl/wheel_slip_brake_release.sv
// Wheel slip brake release: top level, event handling and result register.
// Depends on wsbr_pkg for event codes, status codes and constants.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one event word per
//   accept: func, level and sample. Ticks advance both wheel counters,
//   wheel edges stamp or close a wheel period, and a slider sample yields
//   one result word on the output channel (out_valid / out_stall) with both
//   servo commands, both pulse widths in microseconds and the slip status.
//   Ticks and edges produce no result word.
//   Latency: a sample accepted at one edge shows its result word from the
//   next cycle on. Throughput: one event per cycle unless stalled; the
//   event logic is a single pass from the state registers into the
//   result register. When the receiver stalls, the result word holds and
//   in_stall rises only while that held word is still waiting, so a new
//   event enters as soon as the output register can be overwritten.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes register 0
//   diff_threshold and register 1 max_command; write only while idle.
//   Reset clears counters, stamps, periods, valid marks and the remembered
//   status, sets diff_threshold to 0 and max_command to 235, and empties
//   the output register.
module wheel_slip_brake_release
    import wsbr_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    // event input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [FUNC_BITS-1:0]    func,
    input  logic                    level,
    input  logic [SAMPLE_BITS-1:0]  sample,
    // result output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CMD_BITS-1:0]     front_command,
    output logic [CMD_BITS-1:0]     rear_command,
    output logic [PULSE_BITS-1:0]   front_pulse_us,
    output logic [PULSE_BITS-1:0]   rear_pulse_us,
    output logic [STATUS_BITS-1:0]  slip_status
);

    localparam int CMP_BITS =
        ((COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS) + 2;

    // configuration registers
    logic [THRESH_BITS-1:0] diff_threshold_reg;
    logic [CMD_BITS-1:0]    max_command_reg;

    // wheel state
    logic [COUNT_BITS-1:0] front_ticks_reg,  front_ticks_next;
    logic [COUNT_BITS-1:0] rear_ticks_reg,   rear_ticks_next;
    logic [COUNT_BITS-1:0] front_start_reg,  front_start_next;
    logic [COUNT_BITS-1:0] rear_start_reg,   rear_start_next;
    logic [COUNT_BITS-1:0] front_period_reg, front_period_next;
    logic [COUNT_BITS-1:0] rear_period_reg,  rear_period_next;
    logic                  front_valid_reg,  front_valid_next;
    logic                  rear_valid_reg,   rear_valid_next;
    status_t               last_status_reg,  last_status_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [CMD_BITS-1:0]    front_cmd_reg, front_cmd_next;
    logic [CMD_BITS-1:0]    rear_cmd_reg,  rear_cmd_next;
    logic [PULSE_BITS-1:0]  front_pulse_reg, front_pulse_next;
    logic [PULSE_BITS-1:0]  rear_pulse_reg,  rear_pulse_next;
    status_t                status_reg, status_next;

    logic                   in_accept;
    logic                   result_load;
    logic [CMD_BITS-1:0]    raw_cmd;
    logic [CMD_BITS-1:0]    front_gated;
    logic [CMD_BITS-1:0]    rear_gated;
    logic [COUNT_BITS-1:0]  period_diff;
    logic signed [CMP_BITS-1:0] diff_ext;
    logic signed [CMP_BITS-1:0] thresh_pos;
    logic signed [CMP_BITS-1:0] thresh_neg;
    status_t                eval_status;
    status_t                cur_status;

    // stall only while a held result word is still waiting
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_threshold_reg <= THRESH_RESET;
            max_command_reg    <= MAX_CMD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_data;
                CFG_MAX_COMMAND:    max_command_reg <= cfg_data[CMD_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // compare signed period difference with plus and minus the threshold
    always_comb
    begin
        period_diff = front_period_reg - rear_period_reg;
        diff_ext    = signed'({{(CMP_BITS-COUNT_BITS){period_diff[COUNT_BITS-1]}},
                               period_diff});
        thresh_pos  = signed'({{(CMP_BITS-THRESH_BITS){1'b0}}, diff_threshold_reg});
        thresh_neg  = -thresh_pos;
        if (diff_ext > thresh_pos)
            eval_status = ST_FRONT_SLOW;
        else if (diff_ext < thresh_neg)
            eval_status = ST_REAR_SLOW;
        else
            eval_status = ST_BALANCED;
    end

    // pick fresh or remembered status, gate the slower wheel and clamp
    always_comb
    begin
        raw_cmd    = CMD_BIAS - sample;
        cur_status = (front_valid_reg && rear_valid_reg) ? eval_status
                                                         : last_status_reg;
        front_gated = (cur_status == ST_FRONT_SLOW) ? '0 : raw_cmd;
        rear_gated  = (cur_status == ST_REAR_SLOW)  ? '0 : raw_cmd;
        front_cmd_next = (front_gated > max_command_reg) ? max_command_reg
                                                         : front_gated;
        rear_cmd_next  = (rear_gated > max_command_reg) ? max_command_reg
                                                        : rear_gated;
        front_pulse_next = PULSE_BASE_US + {1'b0, front_cmd_next, 3'b000};
        rear_pulse_next  = PULSE_BASE_US + {1'b0, rear_cmd_next, 3'b000};
        status_next      = cur_status;
    end

    // advance wheel state for the accepted event
    always_comb
    begin
        front_ticks_next  = front_ticks_reg;
        rear_ticks_next   = rear_ticks_reg;
        front_start_next  = front_start_reg;
        rear_start_next   = rear_start_reg;
        front_period_next = front_period_reg;
        rear_period_next  = rear_period_reg;
        front_valid_next  = front_valid_reg;
        rear_valid_next   = rear_valid_reg;
        last_status_next  = last_status_reg;
        result_load       = 1'b0;
        if (in_accept)
        begin
            case (func_t'(func))
                FUNC_TICK:
                begin
                    front_ticks_next = front_ticks_reg + 1'b1;
                    rear_ticks_next  = rear_ticks_reg + 1'b1;
                end
                FUNC_FRONT_EDGE:
                begin
                    if (level)
                        front_start_next = front_ticks_reg;
                    else
                    begin
                        front_period_next = front_ticks_reg - front_start_reg;
                        front_valid_next  = 1'b1;
                        front_ticks_next  = '0;
                    end
                end
                FUNC_REAR_EDGE:
                begin
                    if (level)
                        rear_start_next = rear_ticks_reg;
                    else
                    begin
                        rear_period_next = rear_ticks_reg - rear_start_reg;
                        rear_valid_next  = 1'b1;
                        rear_ticks_next  = '0;
                    end
                end
                FUNC_SAMPLE:
                begin
                    result_load = 1'b1;
                    if (front_valid_reg && rear_valid_reg)
                    begin
                        front_valid_next = 1'b0;
                        rear_valid_next  = 1'b0;
                        last_status_next = eval_status;
                    end
                end
                default: ;
            endcase
        end
    end

    // hold the result word until taken, load a new one on a sample
    always_comb
    begin
        if (result_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // wheel state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ticks_reg  <= '0;
            rear_ticks_reg   <= '0;
            front_start_reg  <= '0;
            rear_start_reg   <= '0;
            front_period_reg <= '0;
            rear_period_reg  <= '0;
            front_valid_reg  <= 1'b0;
            rear_valid_reg   <= 1'b0;
            last_status_reg  <= ST_BALANCED;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            front_ticks_reg  <= front_ticks_next;
            rear_ticks_reg   <= rear_ticks_next;
            front_start_reg  <= front_start_next;
            rear_start_reg   <= rear_start_next;
            front_period_reg <= front_period_next;
            rear_period_reg  <= rear_period_next;
            front_valid_reg  <= front_valid_next;
            rear_valid_reg   <= rear_valid_next;
            last_status_reg  <= last_status_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload, loaded only on a sample
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            front_cmd_reg   <= front_cmd_next;
            rear_cmd_reg    <= rear_cmd_next;
            front_pulse_reg <= front_pulse_next;
            rear_pulse_reg  <= rear_pulse_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign front_command  = front_cmd_reg;
    assign rear_command   = rear_cmd_reg;
    assign front_pulse_us = front_pulse_reg;
    assign rear_pulse_us  = rear_pulse_reg;
    assign slip_status    = status_reg;

endmodule
